// ===== design/mlp_pkg.sv =====
// Shared types, constants and the tanh table for the perceptron inference block.
`timescale 1ns / 1ps

package mlp_pkg;

  localparam int DEF_INPUT_COUNT  = 2;
  localparam int DEF_HIDDEN_COUNT = 8;
  localparam int DEF_OUTPUT_COUNT = 2;

  localparam int ACC_W       = 40;
  localparam int PROD_W      = 33;
  localparam int ACT_W       = 17;
  localparam int TANH_FRAC_W = 25;
  localparam int TANH_IDX_W  = 4;
  localparam int TANH_DIFF_W = 14;
  localparam int SCALE_W     = 47;
  localparam int DIST_SHIFT  = 30;

  localparam logic [23:0] DIST_RECIP = 24'd10737419;
  localparam logic [22:0] DIST_ROUND = 23'd50;
  localparam logic [14:0] Q15_MAX    = 15'h7fff;
  localparam logic signed [ACT_W-1:0] ONE_Q15 = 17'sh08000;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_INFER = 1'b1;

  typedef struct packed {
    logic               action;
    logic [5:0]         weight_index;
    logic signed [15:0] weight_value;
    logic signed [15:0] target_angle;
    logic [15:0]        target_distance;
  } cmd_t;

  typedef struct packed {
    logic signed [15:0] steer_angle;
    logic               move_flag;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SAT,
    ST_LAYER0,
    ST_DRAIN0,
    ST_LAYER1,
    ST_DRAIN1,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ACT_ZERO,
    ACT_ANGLE,
    ACT_DIST,
    ACT_ONE,
    ACT_HIDDEN
  } act_sel_t;

  typedef struct packed {
    logic     valid;
    logic     first;
    logic     last;
    act_sel_t sel;
  } term_t;

  function automatic logic [15:0] tanh_quarter(input logic [4:0] idx);
    logic [15:0] v;
    case (idx)
      5'd0:    v = 16'd0;
      5'd1:    v = 16'd8025;
      5'd2:    v = 16'd15143;
      5'd3:    v = 16'd20813;
      5'd4:    v = 16'd24956;
      5'd5:    v = 16'd27797;
      5'd6:    v = 16'd29660;
      5'd7:    v = 16'd30847;
      5'd8:    v = 16'd31589;
      5'd9:    v = 16'd32048;
      5'd10:   v = 16'd32329;
      5'd11:   v = 16'd32501;
      5'd12:   v = 16'd32606;
      5'd13:   v = 16'd32670;
      5'd14:   v = 16'd32708;
      5'd15:   v = 16'd32732;
      5'd16:   v = 16'd32746;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/mlp_tanh_inference.sv =====
// Top level of the two-layer tanh perceptron inference block.
// A load transaction writes one weight and gives no result.
// An infer transaction passes through the scale, saturate, layer, drain and emit states before its result shows,
// and the next command is accepted only once the sequencer is back in idle;
// one MAC takes a weight per cycle from memory, and the MAC and tanh pipelines drain per layer.
// Reset returns the sequencer to idle and empties the output register; the weight memory is not reset.
`timescale 1ns / 1ps

module mlp_tanh_inference
  import mlp_pkg::*;
#(
  parameter int INPUT_COUNT  = DEF_INPUT_COUNT,
  parameter int HIDDEN_COUNT = DEF_HIDDEN_COUNT,
  parameter int OUTPUT_COUNT = DEF_OUTPUT_COUNT
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int IN_VEC      = INPUT_COUNT + 1;
  localparam int HID_VEC     = HIDDEN_COUNT + 1;
  localparam int W0_SIZE     = IN_VEC * HIDDEN_COUNT;
  localparam int STORE_DEPTH = W0_SIZE + HID_VEC * OUTPUT_COUNT;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int IDX_W       = ((AW > 6) ? AW : 6) + 1;
  localparam int HAW         = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int HCW         = $clog2(HIDDEN_COUNT + 1);
  localparam int JMAX        = (HIDDEN_COUNT > INPUT_COUNT) ? HIDDEN_COUNT : INPUT_COUNT;
  localparam int JW          = $clog2(JMAX + 1);
  localparam int NW          = (HIDDEN_COUNT > 2) ? $clog2(HIDDEN_COUNT) : 1;

  state_t                  state;
  state_t                  state_next;
  logic                    accept;
  logic                    infer_go;
  logic                    emit_go;
  logic                    issuing;
  logic                    layer0;
  logic                    term_last;
  logic [NW-1:0]           last_n;
  term_t                   term;
  logic [AW-1:0]           addr;
  logic [JW-1:0]           j;
  logic [NW-1:0]           n;
  logic [HCW-1:0]          hid_cnt;
  logic                    out_seen;
  logic                    wram_we;
  logic [HAW-1:0]          hid_raddr;
  logic                    hid_we;
  logic signed [15:0]      weight_rd;
  logic signed [15:0]      hidden_rd;
  logic signed [15:0]      angle;
  logic [15:0]             dist_raw;
  logic [22:0]             dist_x;
  logic [SCALE_W-1:0]      scale_prod;
  logic [16:0]             q_full;
  logic [14:0]             dist_q;
  logic                    sum_valid;
  logic signed [ACC_W-1:0] sum;
  logic                    tanh_valid;
  logic signed [15:0]      tanh_value;
  logic signed [15:0]      steer;
  logic                    move;

  assign accept    = cmd_valid && !cmd_stall;
  assign infer_go  = accept && cmd.action == ACTION_INFER;
  assign wram_we   = accept && cmd.action == ACTION_LOAD
                     && IDX_W'(cmd.weight_index) < IDX_W'(STORE_DEPTH);
  assign issuing   = state == ST_LAYER0 || state == ST_LAYER1;
  assign layer0    = state == ST_LAYER0;
  assign term_last = layer0 ? (j == JW'(INPUT_COUNT)) : (j == JW'(HIDDEN_COUNT));
  assign last_n    = layer0 ? NW'(HIDDEN_COUNT - 1) : NW'(1);
  assign hid_raddr = (j < JW'(HIDDEN_COUNT)) ? HAW'(j) : '0;
  assign hid_we    = tanh_valid && (state == ST_LAYER0 || state == ST_DRAIN0);
  assign dist_x    = {dist_raw, 7'd0} + DIST_ROUND;
  assign q_full    = scale_prod[DIST_SHIFT +: 17];

  always_comb begin
    term.valid = issuing;
    term.first = j == '0;
    term.last  = term_last;
    if (layer0) begin
      if (j == '0) begin
        term.sel = ACT_ANGLE;
      end else if (j == JW'(INPUT_COUNT)) begin
        term.sel = ACT_ONE;
      end else if (j == JW'(1)) begin
        term.sel = ACT_DIST;
      end else begin
        term.sel = ACT_ZERO;
      end
    end else begin
      term.sel = (j == JW'(HIDDEN_COUNT)) ? ACT_ONE : ACT_HIDDEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_stall  = state != ST_IDLE;
    emit_go    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && cmd.action == ACTION_INFER) begin
          state_next = ST_SCALE;
        end
      end
      ST_SCALE: state_next = ST_SAT;
      ST_SAT:   state_next = ST_LAYER0;
      ST_LAYER0: begin
        if (term_last && n == last_n) begin
          state_next = ST_DRAIN0;
        end
      end
      ST_DRAIN0: begin
        if (hid_cnt == HCW'(HIDDEN_COUNT)) begin
          state_next = ST_LAYER1;
        end
      end
      ST_LAYER1: begin
        if (term_last && n == last_n) begin
          state_next = ST_DRAIN1;
        end
      end
      ST_DRAIN1: begin
        if (tanh_valid && out_seen) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!res_valid || !res_stall) begin
          emit_go    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr     <= '0;
      j        <= '0;
      n        <= '0;
      hid_cnt  <= '0;
      out_seen <= 1'b0;
    end else begin
      if (infer_go) begin
        addr     <= '0;
        j        <= '0;
        n        <= '0;
        hid_cnt  <= '0;
        out_seen <= 1'b0;
      end
      if (issuing) begin
        addr <= addr + AW'(1);
        if (term_last) begin
          j <= '0;
          n <= (n == last_n) ? '0 : n + NW'(1);
        end else begin
          j <= j + JW'(1);
        end
      end
      if (hid_we) begin
        hid_cnt <= hid_cnt + HCW'(1);
      end
      if (tanh_valid && !hid_we) begin
        out_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (infer_go) begin
      angle    <= cmd.target_angle;
      dist_raw <= cmd.target_distance;
    end
    if (state == ST_SCALE) begin
      scale_prod <= SCALE_W'(dist_x) * SCALE_W'(DIST_RECIP);
    end
    if (state == ST_SAT) begin
      dist_q <= (|q_full[16:15]) ? Q15_MAX : q_full[14:0];
    end
    if (tanh_valid && !hid_we) begin
      if (!out_seen) begin
        steer <= tanh_value;
      end else begin
        move <= !tanh_value[15] && tanh_value != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      res.steer_angle <= steer;
      res.move_flag   <= move;
    end
  end

  mlp_ram #(
    .WIDTH(16),
    .DEPTH(STORE_DEPTH)
  ) u_weight_ram (
    .clk  (clk),
    .we   (wram_we),
    .waddr(AW'(cmd.weight_index)),
    .wdata(cmd.weight_value),
    .raddr(addr),
    .rdata(weight_rd)
  );

  mlp_ram #(
    .WIDTH(16),
    .DEPTH(HIDDEN_COUNT)
  ) u_hidden_ram (
    .clk  (clk),
    .we   (hid_we),
    .waddr(HAW'(hid_cnt)),
    .wdata(tanh_value),
    .raddr(hid_raddr),
    .rdata(hidden_rd)
  );

  mlp_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .term     (term),
    .angle    (angle),
    .dist_q   (dist_q),
    .weight   (weight_rd),
    .hidden   (hidden_rd),
    .sum_valid(sum_valid),
    .sum      (sum)
  );

  mlp_tanh u_tanh (
    .clk      (clk),
    .rst      (rst),
    .sum_valid(sum_valid),
    .sum      (sum),
    .out_valid(tanh_valid),
    .value    (tanh_value)
  );

`ifndef NO_ASSERTIONS
  a_tanh_busy: assert property (@(posedge clk) disable iff (rst)
    tanh_valid |-> (state != ST_IDLE && state != ST_SCALE && state != ST_SAT))
    else $error("Activation result arrived while no inference was in progress.");

  a_hidden_ready: assert property (@(posedge clk) disable iff (rst)
    state == ST_LAYER1 |-> hid_cnt == HCW'(HIDDEN_COUNT))
    else $error("Output layer started before all hidden units were written.");

  a_emit_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == ST_EMIT)
    else $error("Result register loaded outside the emit step.");

  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    wram_we |-> state == ST_IDLE && !sum_valid && !tanh_valid)
    else $error("Weight memory written while an inference was in progress.");
`endif

endmodule

// ===== design/mlp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mlp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mlp_tanh.sv =====
// Three-stage pipelined tanh by linear interpolation of a quarter-step table.
`timescale 1ns / 1ps

module mlp_tanh
  import mlp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sum_valid,
  input  logic signed [ACC_W-1:0] sum,
  output logic                    out_valid,
  output logic signed [15:0]      value
);

  localparam int IP_W = TANH_DIFF_W + TANH_FRAC_W;

  logic                   t1_valid;
  logic                   t1_neg;
  logic                   t1_sat;
  logic [TANH_IDX_W-1:0]  t1_idx;
  logic [TANH_FRAC_W-1:0] t1_frac;
  logic                   t2_valid;
  logic                   t2_neg;
  logic                   t2_sat;
  logic [15:0]            t2_base;
  logic [IP_W-1:0]        t2_prod;
  logic [ACC_W-1:0]       mag;
  logic [15:0]            lo_val;
  logic [15:0]            hi_val;
  logic [TANH_DIFF_W-1:0] diff;
  logic [IP_W-1:0]        rounded;
  logic [16:0]            interp;
  logic [15:0]            clamped;

  assign mag = sum[ACC_W-1] ? ACC_W'(-sum) : ACC_W'(sum);

  always_comb begin
    lo_val  = tanh_quarter({1'b0, t1_idx});
    hi_val  = tanh_quarter(5'({1'b0, t1_idx}) + 5'd1);
    diff    = TANH_DIFF_W'(hi_val - lo_val);
    rounded = t2_prod + IP_W'(1 << (TANH_FRAC_W - 1));
    interp  = 17'(t2_base) + 17'(rounded[IP_W-1:TANH_FRAC_W]);
    clamped = (t2_sat || interp > 17'(Q15_MAX)) ? {1'b0, Q15_MAX} : interp[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid  <= 1'b0;
      t2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      t1_valid  <= sum_valid;
      t2_valid  <= t1_valid;
      out_valid <= t2_valid;
    end
  end

  always_ff @(posedge clk) begin
    t1_neg  <= sum[ACC_W-1];
    t1_sat  <= |mag[ACC_W-1:TANH_FRAC_W+TANH_IDX_W];
    t1_idx  <= mag[TANH_FRAC_W +: TANH_IDX_W];
    t1_frac <= mag[TANH_FRAC_W-1:0];
    t2_neg  <= t1_neg;
    t2_sat  <= t1_sat;
    t2_base <= lo_val;
    t2_prod <= IP_W'(diff) * IP_W'(t1_frac);
    value   <= t2_neg ? -$signed(clamped) : $signed(clamped);
  end

endmodule

// ===== design/mlp_mac.sv =====
// Activation select, weight multiply and neuron accumulator.
`timescale 1ns / 1ps

module mlp_mac
  import mlp_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  term_t                   term,
  input  logic signed [15:0]      angle,
  input  logic [14:0]             dist_q,
  input  logic signed [15:0]      weight,
  input  logic signed [15:0]      hidden,
  output logic                    sum_valid,
  output logic signed [ACC_W-1:0] sum
);

  logic                     p1_valid;
  logic                     p1_first;
  logic                     p1_last;
  act_sel_t                 p1_sel;
  logic                     p2_valid;
  logic                     p2_first;
  logic                     p2_last;
  logic signed [PROD_W-1:0] p2_prod;
  logic signed [ACT_W-1:0]  act;
  logic signed [ACC_W-1:0]  prod_ext;

  always_comb begin
    case (p1_sel)
      ACT_ANGLE:  act = {angle[15], angle};
      ACT_DIST:   act = {2'b00, dist_q};
      ACT_ONE:    act = ONE_Q15;
      ACT_HIDDEN: act = {hidden[15], hidden};
      default:    act = '0;
    endcase
    prod_ext = {{(ACC_W - PROD_W){p2_prod[PROD_W-1]}}, p2_prod};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      p2_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else begin
      p1_valid  <= term.valid;
      p2_valid  <= p1_valid;
      sum_valid <= p2_valid && p2_last;
    end
  end

  always_ff @(posedge clk) begin
    p1_first <= term.first;
    p1_last  <= term.last;
    p1_sel   <= term.sel;
    p2_first <= p1_first;
    p2_last  <= p1_last;
    p2_prod  <= weight * act;
    if (p2_valid) begin
      sum <= p2_first ? prod_ext : sum + prod_ext;
    end
  end

endmodule
